// File: src/sbt8_pkg.sv
`timescale 1ns / 1ps

package sbt8_pkg;

  typedef enum logic [1:0] {
    ENC_CP1252 = 2'd0,
    ENC_TURKISH = 2'd1,
    ENC_LATIN9 = 2'd2,
    ENC_LATIN2 = 2'd3
  } sbt8_enc_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } sbt8_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       text_done;
  } sbt8_out_t;

  localparam logic [15:0] BASE_MAP [32] = '{
    16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
    16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
  };

  localparam logic [15:0] LATIN2_HI [96] = '{
    16'h00A0, 16'h0104, 16'h02D8, 16'h0141, 16'h00A4, 16'h013D, 16'h015A, 16'h00A7,
    16'h00A8, 16'h0160, 16'h015E, 16'h0164, 16'h0179, 16'h00AD, 16'h017D, 16'h017B,
    16'h00B0, 16'h0105, 16'h02DB, 16'h0142, 16'h00B4, 16'h013E, 16'h015B, 16'h02C7,
    16'h00B8, 16'h0161, 16'h015F, 16'h0165, 16'h017A, 16'h02DD, 16'h017E, 16'h017C,
    16'h0154, 16'h00C1, 16'h00C2, 16'h0102, 16'h00C4, 16'h0139, 16'h0106, 16'h00C7,
    16'h010C, 16'h00C9, 16'h0118, 16'h00CB, 16'h011A, 16'h00CD, 16'h00CE, 16'h010E,
    16'h0110, 16'h0143, 16'h0147, 16'h00D3, 16'h00D4, 16'h0150, 16'h00D6, 16'h00D7,
    16'h0158, 16'h016E, 16'h00DA, 16'h0170, 16'h00DC, 16'h00DD, 16'h0162, 16'h00DF,
    16'h0155, 16'h00E1, 16'h00E2, 16'h0103, 16'h00E4, 16'h013A, 16'h0107, 16'h00E7,
    16'h010D, 16'h00E9, 16'h0119, 16'h00EB, 16'h011B, 16'h00ED, 16'h00EE, 16'h010F,
    16'h0111, 16'h0144, 16'h0148, 16'h00F3, 16'h00F4, 16'h0151, 16'h00F6, 16'h00F7,
    16'h0159, 16'h016F, 16'h00FA, 16'h0171, 16'h00FC, 16'h00FD, 16'h0163, 16'h02D9
  };

  function automatic logic [15:0] sbt8_turkish(input logic [7:0] b);
    logic [15:0] cp;
    case (b)
      8'hD0:   cp = 16'h011E;
      8'hDD:   cp = 16'h0130;
      8'hDE:   cp = 16'h015E;
      8'hF0:   cp = 16'h011F;
      8'hFD:   cp = 16'h0131;
      8'hFE:   cp = 16'h015F;
      default: cp = {8'h00, b};
    endcase
    return cp;
  endfunction

  function automatic logic [15:0] sbt8_latin9(input logic [7:0] b);
    logic [15:0] cp;
    case (b)
      8'hA4:   cp = 16'h20AC;
      8'hA6:   cp = 16'h0160;
      8'hA8:   cp = 16'h0161;
      8'hB4:   cp = 16'h017D;
      8'hB8:   cp = 16'h017E;
      8'hBC:   cp = 16'h0152;
      8'hBD:   cp = 16'h0153;
      8'hBE:   cp = 16'h0178;
      default: cp = {8'h00, b};
    endcase
    return cp;
  endfunction

  function automatic logic [15:0] sbt8_code_point(input logic [7:0] b, input sbt8_enc_e enc);
    logic [15:0] cp;
    logic [7:0]  l2_off;
    l2_off = b - 8'hA0;
    if (!b[7]) begin
      cp = {8'h00, b};
    end else if (b < 8'hA0) begin
      cp = BASE_MAP[b[4:0]];
    end else begin
      unique case (enc)
        ENC_TURKISH: cp = sbt8_turkish(b);
        ENC_LATIN9:  cp = sbt8_latin9(b);
        ENC_LATIN2:  cp = LATIN2_HI[l2_off[6:0]];
        default:     cp = {8'h00, b};
      endcase
    end
    return cp;
  endfunction

endpackage

// File: src/sbt8_cp_rom.sv
`timescale 1ns / 1ps

module sbt8_cp_rom import sbt8_pkg::*; (
  input  logic        clk_i,
  input  logic        rd_en_i,
  input  logic [7:0]  byte_i,
  input  sbt8_enc_e   enc_i,
  output logic [15:0] cp_o
);

  logic [15:0] cp_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      cp_q <= sbt8_code_point(byte_i, enc_i);
    end
  end

  assign cp_o = cp_q;

endmodule

// File: src/single_byte_to_utf8_transcoder_unit.sv
`timescale 1ns / 1ps

// Channel | Dir | Handshake              | Beat
// in      | in  | in_valid_i/in_ready_o  | sbt8_in_t  (source byte, end of text)
// out     | out | out_valid_o/out_ready_i| sbt8_out_t (UTF-8 byte, last of run, done)
// cfg     | in  | cfg_valid_i/cfg_ready_o| 2-bit encoding select
//
// One output beat per cycle while out_ready_i accepts; an input byte yields 1, 2 or 3
// UTF-8 bytes, emitted one by one by the byte serialiser. An input beat reaches the
// output through the code-point ROM read, the serialiser and the output register.
// Reset clears the encoding to windows-1252 and empties all stages.
// A stall on out holds the output register and backs up through the serialiser
// and the lookup stage to in_ready_o.

module single_byte_to_utf8_transcoder_unit import sbt8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  sbt8_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output sbt8_out_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  sbt8_enc_e   enc_q;
  logic        in_acc;

  logic        s1_valid_q, s1_valid_d;
  logic        s1_eot_q;
  logic [15:0] s1_cp;
  logic        s1_move;

  logic        ser_valid_q, ser_valid_d;
  logic [15:0] ser_cp_q;
  logic [1:0]  ser_len_q;
  logic [1:0]  ser_idx_q;
  logic        ser_eot_q;
  logic        ser_last;
  logic        ser_free;
  logic        emit;
  logic [1:0]  new_len;
  logic [7:0]  ser_byte;

  logic        out_valid_q, out_valid_d;
  sbt8_out_t   out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q <= ENC_CP1252;
    end else if (cfg_valid_i) begin
      enc_q <= sbt8_enc_e'(cfg_data_i);
    end
  end

  assign emit     = ser_valid_q && (!out_valid_q || out_ready_i);
  assign ser_last = (ser_idx_q == (ser_len_q - 2'd1));
  assign ser_free = !ser_valid_q || (emit && ser_last);
  assign s1_move  = s1_valid_q && ser_free;

  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_acc     = in_valid_i && in_ready_o;

  sbt8_cp_rom u_cp_rom (
    .clk_i   (clk_i),
    .rd_en_i (in_acc),
    .byte_i  (in_data_i.in_byte),
    .enc_i   (enc_q),
    .cp_o    (s1_cp)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_eot_q <= in_data_i.end_of_text;
    end
  end

  always_comb begin
    if (s1_cp < 16'h0080) begin
      new_len = 2'd1;
    end else if (s1_cp < 16'h0800) begin
      new_len = 2'd2;
    end else begin
      new_len = 2'd3;
    end
  end

  always_comb begin
    ser_valid_d = ser_valid_q;
    if (s1_move) begin
      ser_valid_d = 1'b1;
    end else if (emit && ser_last) begin
      ser_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      ser_idx_q   <= 2'd0;
    end else begin
      ser_valid_q <= ser_valid_d;
      if (s1_move) begin
        ser_idx_q <= 2'd0;
      end else if (emit && !ser_last) begin
        ser_idx_q <= ser_idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      ser_cp_q  <= s1_cp;
      ser_len_q <= new_len;
      ser_eot_q <= s1_eot_q;
    end
  end

  always_comb begin
    ser_byte = ser_cp_q[7:0];
    case (ser_len_q)
      2'd2: begin
        if (ser_idx_q == 2'd0) begin
          ser_byte = {3'b110, ser_cp_q[10:6]};
        end else begin
          ser_byte = {2'b10, ser_cp_q[5:0]};
        end
      end
      2'd3: begin
        if (ser_idx_q == 2'd0) begin
          ser_byte = {4'b1110, ser_cp_q[15:12]};
        end else if (ser_idx_q == 2'd1) begin
          ser_byte = {2'b10, ser_cp_q[11:6]};
        end else begin
          ser_byte = {2'b10, ser_cp_q[5:0]};
        end
      end
      default: ser_byte = ser_cp_q[7:0];
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_byte    <= ser_byte;
      out_q.last_of_run <= ser_last;
      out_q.text_done   <= ser_last && ser_eot_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_valid_q |-> (ser_idx_q < ser_len_q))
    else $error("serialiser index beyond run length");

  a_done_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.text_done || out_q.last_of_run))
    else $error("text done beat not closing its run");

  a_lead_not_ascii : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last_of_run) |-> out_q.out_byte[7])
    else $error("multi-byte run carries an ASCII byte");

  a_hold_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !ser_free) |-> !in_ready_o)
    else $error("input taken while lookup stage blocked");

endmodule
